### hdl/mds_pkg.sv
// Morse symbol decoder: shared types, constants and the code table lookup.
// Used by every module of the decoder; depends on nothing.
`default_nettype none

package mds_pkg;

    // Longest code that is stored; longer groups read as unknown
    localparam int MAX_CODE_LEN = 8;
    localparam int CODE_W       = MAX_CODE_LEN;
    localparam int LEN_W        = $clog2(MAX_CODE_LEN + 2);
    localparam int TBL_LEN_W    = 4;
    localparam int TBL_BITS_W   = 8;
    localparam int LCMP_W       = (LEN_W > TBL_LEN_W) ? LEN_W : TBL_LEN_W;
    localparam int BCMP_W       = (CODE_W > TBL_BITS_W) ? CODE_W : TBL_BITS_W;
    localparam int CHAR_W       = 7;

    // Symbol codes
    localparam logic [1:0] SYM_DIT = 2'd0;
    localparam logic [1:0] SYM_DAH = 2'd1;
    localparam logic [1:0] SYM_GAP = 2'd2;

    // Characters the block produces on its own
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_E       = 7'h45;
    localparam logic [CHAR_W-1:0] CHAR_R       = 7'h52;
    localparam logic [CHAR_W-1:0] ERR_MARK     = 7'h00;
    localparam logic [CHAR_W-1:0] UNKNOWN_INIT = 7'h3F;

    // Results of the error group: E, R, R
    localparam int ERR_COUNT = 3;
    localparam int SEQ_W     = $clog2(ERR_COUNT);

    // Queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [CHAR_W-1:0]     ch;
        logic [TBL_LEN_W-1:0]  len;
        logic [TBL_BITS_W-1:0] bits;
    } entry_t;

    // One queued job: a single character, or the three-character error group
    typedef struct packed {
        logic              err3;
        logic [CHAR_W-1:0] ch;
    } job_t;

    typedef struct packed {
        logic              hit;
        logic              err3;
        logic [CHAR_W-1:0] ch;
    } lookup_t;

    localparam int TABLE_N = 53;

    // Elements first-sent in the most significant position, 0 dit, 1 dah
    localparam entry_t MORSE_TABLE [TABLE_N] = '{
        '{7'h21, 4'd6, 8'h2B}, '{7'h24, 4'd7, 8'h09}, '{7'h22, 4'd6, 8'h12},
        '{7'h27, 4'd6, 8'h1E}, '{7'h28, 4'd5, 8'h16}, '{7'h29, 4'd6, 8'h2D},
        '{7'h2C, 4'd6, 8'h33}, '{7'h2D, 4'd6, 8'h21}, '{7'h2E, 4'd6, 8'h15},
        '{7'h2F, 4'd5, 8'h12}, '{7'h30, 4'd5, 8'h1F}, '{7'h31, 4'd5, 8'h0F},
        '{7'h32, 4'd5, 8'h07}, '{7'h33, 4'd5, 8'h03}, '{7'h34, 4'd5, 8'h01},
        '{7'h35, 4'd5, 8'h00}, '{7'h36, 4'd5, 8'h10}, '{7'h37, 4'd5, 8'h18},
        '{7'h38, 4'd5, 8'h1C}, '{7'h39, 4'd5, 8'h1E}, '{7'h3A, 4'd6, 8'h38},
        '{7'h3B, 4'd6, 8'h2A}, '{7'h3D, 4'd5, 8'h11}, '{7'h3F, 4'd6, 8'h0C},
        '{7'h40, 4'd6, 8'h1A}, '{7'h41, 4'd2, 8'h01}, '{7'h42, 4'd4, 8'h08},
        '{7'h43, 4'd4, 8'h0A}, '{7'h44, 4'd3, 8'h04}, '{7'h45, 4'd1, 8'h00},
        '{7'h46, 4'd4, 8'h02}, '{7'h47, 4'd3, 8'h06}, '{7'h48, 4'd4, 8'h00},
        '{7'h49, 4'd2, 8'h00}, '{7'h4A, 4'd4, 8'h07}, '{7'h4B, 4'd3, 8'h05},
        '{7'h4C, 4'd4, 8'h04}, '{7'h4D, 4'd2, 8'h03}, '{7'h4E, 4'd2, 8'h02},
        '{7'h4F, 4'd3, 8'h07}, '{7'h50, 4'd4, 8'h06}, '{7'h51, 4'd4, 8'h0D},
        '{7'h52, 4'd3, 8'h02}, '{7'h53, 4'd3, 8'h00}, '{7'h54, 4'd1, 8'h01},
        '{7'h55, 4'd3, 8'h01}, '{7'h56, 4'd4, 8'h01}, '{7'h57, 4'd3, 8'h03},
        '{7'h58, 4'd4, 8'h09}, '{7'h59, 4'd4, 8'h0B}, '{7'h5A, 4'd4, 8'h0C},
        '{7'h5F, 4'd6, 8'h0D}, '{ERR_MARK, 4'd8, 8'h00}
    };

    // Match a code group against every table entry in parallel
    function automatic lookup_t mds_lookup(input logic [LEN_W-1:0]  len,
                                           input logic [CODE_W-1:0] bits);
        lookup_t r;
        r.hit  = 1'b0;
        r.err3 = 1'b0;
        r.ch   = '0;
        for (int i = 0; i < TABLE_N; i++)
        begin
            if ((len <= LEN_W'(MAX_CODE_LEN)) &&
                (LCMP_W'(MORSE_TABLE[i].len) == LCMP_W'(len)) &&
                (BCMP_W'(MORSE_TABLE[i].bits) == BCMP_W'(bits)))
            begin
                r.hit  = 1'b1;
                r.err3 = (MORSE_TABLE[i].ch == ERR_MARK);
                r.ch   = MORSE_TABLE[i].ch;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/mds_sym_if.sv
// Symbol channel of the Morse decoder: valid/ready plus symbol payload.
// Depends on nothing.
`default_nettype none

interface mds_sym_if;
    logic       valid;
    logic       ready;
    logic [1:0] symbol;
    logic       end_of_message;

    modport source (output valid, output symbol, output end_of_message, input ready);
    modport sink   (input valid, input symbol, input end_of_message, output ready);
endinterface

`default_nettype wire

### hdl/mds_char_if.sv
// Character channel of the Morse decoder: valid/ready plus character payload.
// Depends on nothing.
`default_nettype none

interface mds_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

### hdl/mds_front.sv
// Front of the Morse decoder: accepts symbols, keeps the code group state,
// looks groups up and pushes jobs. Depends on mds_pkg and mds_sym_if.
`default_nettype none

module mds_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    mds_sym_if.sink            sym_in,
    input  wire logic          cfg_we,
    input  wire logic [6:0]    cfg_wdata,
    input  wire logic          q_full,
    output logic               push,
    output mds_pkg::job_t      push_job
);

    logic [mds_pkg::CODE_W-1:0]  bits_reg,  bits_next;
    logic [mds_pkg::LEN_W-1:0]   len_reg,   len_next;
    logic                        pws_reg,   pws_next;
    logic [mds_pkg::CHAR_W-1:0]  unknown_reg;

    logic                        accept;
    logic                        is_elem;
    logic                        is_gap;
    logic [mds_pkg::CODE_W-1:0]  bits_s;
    logic [mds_pkg::LEN_W-1:0]   len_s;
    logic                        flush;
    logic                        space;
    mds_pkg::lookup_t            hit;

    assign sym_in.ready = !q_full;
    assign accept       = sym_in.valid && sym_in.ready;
    assign is_elem      = sym_in.symbol inside {mds_pkg::SYM_DIT, mds_pkg::SYM_DAH};
    assign is_gap       = (sym_in.symbol == mds_pkg::SYM_GAP);

    // Shift a dit or dah into the group, saturate the length past the limit
    always_comb
    begin
        bits_s = bits_reg;
        len_s  = len_reg;
        if (is_elem)
        begin
            if (len_reg < mds_pkg::LEN_W'(mds_pkg::MAX_CODE_LEN))
            begin
                bits_s = {bits_reg[mds_pkg::CODE_W-2:0], sym_in.symbol[0]};
                len_s  = len_reg + 1'b1;
            end
            else
            begin
                len_s = mds_pkg::LEN_W'(mds_pkg::MAX_CODE_LEN + 1);
            end
        end
    end

    // Classify: flush a pending group on gap or end of message, else maybe a space
    assign flush = (is_gap && (len_reg != '0)) ||
                   (sym_in.end_of_message && (len_s != '0));
    assign space = is_gap && (len_reg == '0) && !pws_reg;
    assign hit   = mds_pkg::mds_lookup(len_s, bits_s);

    always_comb
    begin
        push          = accept && (flush || space);
        push_job.err3 = 1'b0;
        push_job.ch   = mds_pkg::CHAR_SPACE;
        if (flush)
        begin
            push_job.err3 = hit.hit && hit.err3;
            push_job.ch   = hit.hit ? hit.ch : unknown_reg;
        end
    end

    // Next group state
    always_comb
    begin
        bits_next = bits_s;
        len_next  = len_s;
        pws_next  = pws_reg;
        if (flush || sym_in.end_of_message)
        begin
            bits_next = '0;
            len_next  = '0;
            pws_next  = 1'b0;
        end
        else if (space)
        begin
            pws_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg    <= '0;
            len_reg     <= '0;
            pws_reg     <= 1'b0;
            unknown_reg <= mds_pkg::UNKNOWN_INIT;
        end
        else
        begin
            if (accept)
            begin
                bits_reg <= bits_next;
                len_reg  <= len_next;
                pws_reg  <= pws_next;
            end
            if (cfg_we)
            begin
                unknown_reg <= cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/mds_queue.sv
// Short job queue between front and back of the Morse decoder.
// Depends on mds_pkg.
`default_nettype none

module mds_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mds_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               q_valid,
    output mds_pkg::job_t      q_job
);

    mds_pkg::job_t               slot_reg [mds_pkg::QDEPTH];
    logic [mds_pkg::QPTR_W-1:0]  wr_reg, wr_next;
    logic [mds_pkg::QPTR_W-1:0]  rd_reg, rd_next;
    logic [mds_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;
    logic                        do_pop;

    assign full    = (cnt_reg == mds_pkg::QCNT_W'(mds_pkg::QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_job   = slot_reg[rd_reg];
    assign do_pop  = pop && q_valid;

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == mds_pkg::QPTR_W'(mds_pkg::QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == mds_pkg::QPTR_W'(mds_pkg::QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### hdl/mds_back.sv
// Back of the Morse decoder: expands queued jobs into characters and holds
// them in the output register. Depends on mds_pkg and mds_char_if.
`default_nettype none

module mds_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire mds_pkg::job_t q_job,
    output logic               pop,
    mds_char_if.source         char_out
);

    logic                        ovalid_reg, ovalid_next;
    logic [mds_pkg::CHAR_W-1:0]  ochar_reg,  ochar_next;
    logic                        olast_reg,  olast_next;
    logic [mds_pkg::SEQ_W-1:0]   seq_reg,    seq_next;
    logic                        load;
    logic                        seq_end;

    assign char_out.valid     = ovalid_reg;
    assign char_out.char_code = ochar_reg;
    assign char_out.last      = olast_reg;

    // Output register frees up when empty or when its transfer completes
    assign load    = !ovalid_reg || char_out.ready;
    assign seq_end = (seq_reg == mds_pkg::SEQ_W'(mds_pkg::ERR_COUNT - 1));

    always_comb
    begin
        ovalid_next = ovalid_reg;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        seq_next    = seq_reg;
        pop         = 1'b0;
        if (load)
        begin
            ovalid_next = q_valid;
            if (q_valid)
            begin
                if (q_job.err3)
                begin
                    // Step through E, R, R; drop the job after the last one
                    ochar_next = (seq_reg == '0) ? mds_pkg::CHAR_E : mds_pkg::CHAR_R;
                    olast_next = seq_end;
                    pop        = seq_end;
                    seq_next   = seq_end ? '0 : seq_reg + 1'b1;
                end
                else
                begin
                    ochar_next = q_job.ch;
                    olast_next = 1'b1;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            seq_reg    <= '0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            seq_reg    <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

endmodule

`default_nettype wire

### hdl/morse_symbol_decoder.sv
// Top level of the Morse symbol decoder: front, job queue and back.
// Depends on mds_pkg, mds_sym_if, mds_char_if, mds_front, mds_queue, mds_back.
//
//   channel    dir   payload                       transfer when
//   sym_in     in    symbol[1:0], end_of_message   valid && ready
//   char_out   out   char_code[6:0], last          valid && ready
//   cfg        in    cfg_wdata[6:0]                cfg_we
//
// A symbol is taken every cycle while the two-entry job queue has room.
// After its symbol is taken, each character passes through the job queue and then
// the output register; the back gives out the error group E, R, R one character at a time.
// Reset clears the code group, the queue and the output register, and sets
// the unknown character to '?'. A stall on char_out holds the output register
// and backs up into the queue, then into sym_in.ready.
`default_nettype none

module morse_symbol_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    mds_sym_if.sink         sym_in,
    mds_char_if.source      char_out,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata
);

    logic           push;
    mds_pkg::job_t  push_job;
    logic           q_full;
    logic           pop;
    logic           q_valid;
    mds_pkg::job_t  q_job;

    mds_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_in    (sym_in),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    mds_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    mds_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .pop      (pop),
        .char_out (char_out)
    );

endmodule

`default_nettype wire

### hdl/mds_checker.sv
// Port-level checks for the Morse symbol decoder, bound to the top level.
// Depends on mds_pkg and morse_symbol_decoder.
`default_nettype none

module mds_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [6:0] out_char,
    input wire logic       out_last
);

    // Hold a stalled character
    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("char_out valid dropped while stalled");

    a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_char) && $stable(out_last)))
        else $error("char_out payload changed while stalled");

    // Only the error group gives more than one character per symbol
    a_multi_err : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) |->
            (out_char == mds_pkg::CHAR_E || out_char == mds_pkg::CHAR_R))
        else $error("non-final character outside the error group");

    // A fresh character follows a symbol transfer: the job goes into the queue,
    // then into the output register
    a_rise_cause : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("char_out valid rose without a symbol transfer");

endmodule

bind morse_symbol_decoder mds_checker u_mds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sym_in.valid),
    .in_ready  (sym_in.ready),
    .out_valid (char_out.valid),
    .out_ready (char_out.ready),
    .out_char  (char_out.char_code),
    .out_last  (char_out.last)
);

`default_nettype wire

### bench/tb_morse_symbol_decoder.sv
// Testbench for morse_symbol_decoder: a directed symbol table, then random code groups,
// checked against a behavioural decoder model with random stalls on both channels.
// Depends on mds_pkg, mds_sym_if, mds_char_if and the morse_symbol_decoder RTL.
`timescale 1ns / 1ps

module tb_morse_symbol_decoder;

    localparam logic [1:0] SYM_NONE    = 2'd3;   // unused symbol value, ignored
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DRAIN_WAIT  = 6;
    localparam int         PHASE_ITEMS = 80;
    localparam int         N_DIRECTED  = 25;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } char_res_t;

    typedef struct packed {
        logic [1:0] sym;
        logic       eom;
        logic       typed;
        logic [1:0] n;
        logic [6:0] c0;
        logic [6:0] c1;
        logic [6:0] c2;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [6:0] cfg_wdata;

    mds_sym_if  sym_in ();
    mds_char_if char_out ();

    morse_symbol_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_in    (sym_in),
        .char_out  (char_out),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Decoder model state
    logic [7:0] code_reg;
    logic [3:0] code_len;
    logic       space_sent;
    logic [6:0] unknown_ch;

    char_res_t  expected_chars [$];
    char_res_t  decoded_batch [$];
    char_res_t  oldest;
    stim_row_t  directed_rows [N_DIRECTED];

    int fail_count;
    int phase_items;
    int src_burst;
    int cycle_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 6);
        else
            return $urandom_range(10, 30);
    endfunction

    // Add one character to the tail of the scoreboard
    function automatic void expect_char(input char_res_t r);
        expected_chars.insert(expected_chars.size(), r);
    endfunction

    // Add one predicted character of the current symbol
    function automatic void predict_char(input logic [6:0] c);
        char_res_t r;
        r.ch   = c;
        r.last = 1'b0;
        decoded_batch.insert(decoded_batch.size(), r);
    endfunction

    // Code group to character; bit 7 set on a table hit
    function automatic logic [7:0] morse_to_ascii(input logic [3:0] len, input logic [7:0] bits);
        logic [6:0] ch;
        logic       hit;
        hit = 1'b1;
        ch  = '0;
        case ({len, bits})
            12'h100: ch = 7'h45;   12'h101: ch = 7'h54;   12'h200: ch = 7'h49;  // E T I
            12'h201: ch = 7'h41;   12'h202: ch = 7'h4E;   12'h203: ch = 7'h4D;  // A N M
            12'h300: ch = 7'h53;   12'h301: ch = 7'h55;   12'h302: ch = 7'h52;  // S U R
            12'h303: ch = 7'h57;   12'h304: ch = 7'h44;   12'h305: ch = 7'h4B;  // W D K
            12'h306: ch = 7'h47;   12'h307: ch = 7'h4F;   12'h400: ch = 7'h48;  // G O H
            12'h401: ch = 7'h56;   12'h402: ch = 7'h46;   12'h404: ch = 7'h4C;  // V F L
            12'h406: ch = 7'h50;   12'h407: ch = 7'h4A;   12'h408: ch = 7'h42;  // P J B
            12'h409: ch = 7'h58;   12'h40A: ch = 7'h43;   12'h40B: ch = 7'h59;  // X C Y
            12'h40C: ch = 7'h5A;   12'h40D: ch = 7'h51;                          // Z Q
            12'h500: ch = 7'h35;   12'h501: ch = 7'h34;   12'h503: ch = 7'h33;  // 5 4 3
            12'h507: ch = 7'h32;   12'h50F: ch = 7'h31;   12'h51F: ch = 7'h30;  // 2 1 0
            12'h510: ch = 7'h36;   12'h518: ch = 7'h37;   12'h51C: ch = 7'h38;  // 6 7 8
            12'h51E: ch = 7'h39;   12'h511: ch = 7'h3D;   12'h512: ch = 7'h2F;  // 9 = /
            12'h516: ch = 7'h28;   12'h62B: ch = 7'h21;   12'h612: ch = 7'h22;  // ( ! "
            12'h61E: ch = 7'h27;   12'h62D: ch = 7'h29;   12'h633: ch = 7'h2C;  // ' ) ,
            12'h621: ch = 7'h2D;   12'h615: ch = 7'h2E;   12'h638: ch = 7'h3A;  // - . :
            12'h62A: ch = 7'h3B;   12'h60C: ch = 7'h3F;   12'h61A: ch = 7'h40;  // ; ? @
            12'h60D: ch = 7'h5F;   12'h709: ch = 7'h24;                          // _ $
            12'h800: ch = mds_pkg::ERR_MARK;                                     // E R R
            default: hit = 1'b0;
        endcase
        return {hit, ch};
    endfunction

    // Emit the character(s) of the pending group and clear it
    task automatic flush_code();
        logic [7:0] look;
        look = morse_to_ascii(code_len, code_reg);
        if (code_len <= 4'(mds_pkg::MAX_CODE_LEN) && look[7])
        begin
            if (look[6:0] == mds_pkg::ERR_MARK)
            begin
                predict_char(mds_pkg::CHAR_E);
                predict_char(mds_pkg::CHAR_R);
                predict_char(mds_pkg::CHAR_R);
            end
            else
                predict_char(look[6:0]);
        end
        else
            predict_char(unknown_ch);
        code_reg   = '0;
        code_len   = '0;
        space_sent = 1'b0;
    endtask

    // Advance the model by one symbol; results land in decoded_batch
    task automatic predict_symbol(input logic [1:0] s, input logic e);
        decoded_batch.delete();
        if (s == mds_pkg::SYM_DIT || s == mds_pkg::SYM_DAH)
        begin
            if (code_len < 4'(mds_pkg::MAX_CODE_LEN))
            begin
                code_reg = {code_reg[6:0], s[0]};
                code_len = code_len + 4'd1;
            end
            else
                code_len = 4'(mds_pkg::MAX_CODE_LEN + 1);
        end
        else if (s == mds_pkg::SYM_GAP)
        begin
            if (code_len != 0)
                flush_code();
            else if (!space_sent)
            begin
                predict_char(mds_pkg::CHAR_SPACE);
                space_sent = 1'b1;
            end
        end
        if (e)
        begin
            if (code_len != 0)
                flush_code();
            code_reg   = '0;
            code_len   = '0;
            space_sent = 1'b0;
        end
        if (decoded_batch.size() > 0)
            decoded_batch[decoded_batch.size() - 1].last = 1'b1;
    endtask

    // Offer one symbol and hold it until the transfer
    task automatic send_symbol(input logic [1:0] s, input logic e);
        int idle_n;
        if (src_burst > 0)
        begin
            src_burst--;
            idle_n = 0;
        end
        else if ($urandom_range(0, 49) == 0)
        begin
            src_burst = 30;
            idle_n    = 0;
        end
        else
            idle_n = pick_idle();
        if (idle_n > 0)
        begin
            sym_in.valid <= 1'b0;
            repeat (idle_n) @(posedge clk);
        end
        sym_in.valid          <= 1'b1;
        sym_in.symbol         <= s;
        sym_in.end_of_message <= e;
        @(posedge clk);
        while (!sym_in.ready)
            @(posedge clk);
    endtask

    task automatic apply_symbol(input logic [1:0] s, input logic e);
        send_symbol(s, e);
        predict_symbol(s, e);
        while (decoded_batch.size() > 0)
            expect_char(decoded_batch.pop_front());
        if (s != SYM_NONE || e)
            phase_items++;
    endtask

    // Stop offering and wait for every expected character, then let the block settle
    task automatic drain_results();
        sym_in.valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_unknown_char(input logic [6:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        unknown_ch = v;
    endtask

    // One code group of random content, mostly well formed
    task automatic send_code_group();
        int r;
        int len;
        int k;
        int ending;
        logic [10:0] bits;
        r    = $urandom_range(0, 99);
        bits = 11'($urandom);
        if (r < 5)
        begin
            len  = 8;
            bits = '0;
        end
        else if (r < 8)
        begin
            len  = 7;
            bits = 11'h009;
        end
        else if (r < 55)
            len = $urandom_range(1, 4);
        else if (r < 75)
            len = 5;
        else if (r < 87)
            len = 6;
        else if (r < 92)
            len = 7;
        else if (r < 95)
            len = 8;
        else
            len = $urandom_range(9, 11);
        // 0-4 gap, 5 flag on last element, 6 gap with flag, 7-8 two gaps, 9 run on
        ending = $urandom_range(0, 9);
        for (k = len - 1; k >= 0; k--)
        begin
            if ($urandom_range(0, 29) == 0)
                apply_symbol(SYM_NONE, 1'b0);
            apply_symbol(bits[k] ? mds_pkg::SYM_DAH : mds_pkg::SYM_DIT,
                         (ending == 5) && (k == 0));
        end
        if (ending != 5 && ending != 9)
            apply_symbol(mds_pkg::SYM_GAP, ending == 6);
        if (ending == 7 || ending == 8)
            apply_symbol(mds_pkg::SYM_GAP, 1'b0);
    endtask

    task automatic run_random_phase();
        phase_items = 0;
        while (phase_items < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                apply_symbol(2'($urandom_range(0, 3)), $urandom_range(0, 7) == 0);
            else
                send_code_group();
        end
    endtask

    // Stimulus
    initial
    begin : stimulus
        int i;
        int j;
        stim_row_t row;
        char_res_t res;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;
        sym_in.valid          <= 1'b0;
        sym_in.symbol         <= mds_pkg::SYM_DIT;
        sym_in.end_of_message <= 1'b0;
        code_reg   = '0;
        code_len   = '0;
        space_sent = 1'b0;
        unknown_ch = mds_pkg::UNKNOWN_INIT;
        fail_count = 0;
        src_burst  = 0;

        directed_rows = '{
            '{mds_pkg::SYM_GAP, 1'b0, 1'b1, 2'd1, mds_pkg::CHAR_SPACE, 7'h00, 7'h00},
            '{mds_pkg::SYM_GAP, 1'b0, 1'b1, 2'd0, 7'h00, 7'h00, 7'h00},
            '{SYM_NONE,         1'b1, 1'b1, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_GAP, 1'b0, 1'b1, 2'd1, mds_pkg::CHAR_SPACE, 7'h00, 7'h00},
            '{mds_pkg::SYM_DIT, 1'b1, 1'b1, 2'd1, mds_pkg::CHAR_E, 7'h00, 7'h00},
            '{mds_pkg::SYM_DAH, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_GAP, 1'b0, 1'b1, 2'd1, 7'h54, 7'h00, 7'h00},
            '{mds_pkg::SYM_DIT, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_DIT, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_DIT, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_DIT, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_DIT, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_DIT, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_DIT, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_DIT, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_GAP, 1'b0, 1'b1, 2'd3, mds_pkg::CHAR_E, mds_pkg::CHAR_R,
              mds_pkg::CHAR_R},
            '{mds_pkg::SYM_DAH, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_DAH, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_DAH, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_DAH, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_DAH, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_DAH, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_DAH, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_DAH, 1'b0, 1'b0, 2'd0, 7'h00, 7'h00, 7'h00},
            '{mds_pkg::SYM_DAH, 1'b1, 1'b1, 2'd1, mds_pkg::UNKNOWN_INIT, 7'h00, 7'h00}
        };

        // Hold reset, then release
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: typed rows carry their own characters, others use the model
        for (i = 0; i < N_DIRECTED; i++)
        begin
            row = directed_rows[i];
            send_symbol(row.sym, row.eom);
            predict_symbol(row.sym, row.eom);
            if (row.typed)
            begin
                for (j = 0; j < int'(row.n); j++)
                begin
                    res.ch   = (j == 0) ? row.c0 : (j == 1) ? row.c1 : row.c2;
                    res.last = (j == int'(row.n) - 1);
                    expect_char(res);
                end
            end
            else
            begin
                while (decoded_batch.size() > 0)
                    expect_char(decoded_batch.pop_front());
            end
        end

        // Random phases over several unknown-character settings
        write_unknown_char(7'h7F);
        run_random_phase();
        write_unknown_char(7'h00);
        run_random_phase();
        write_unknown_char(7'($urandom_range(1, 126)));
        run_random_phase();
        write_unknown_char(mds_pkg::UNKNOWN_INIT);
        run_random_phase();
        write_unknown_char(7'($urandom_range(0, 127)));
        run_random_phase();

        drain_results();
        if (fail_count == 0)
            $display("tb_morse_symbol_decoder OK");
        else
            $display("tb_morse_symbol_decoder NOT OK");
        $finish;
    end

    // Character sink: random stalls, bursts of full rate, one long hold-off
    initial
    begin : char_sink
        int stall_left;
        int burst_left;
        int sink_cycles;
        bit long_done;
        stall_left  = 0;
        burst_left  = 0;
        sink_cycles = 0;
        long_done   = 1'b0;
        char_out.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            sink_cycles++;
            if (!long_done && sink_cycles >= 400 && sym_in.valid)
            begin
                long_done  = 1'b1;
                stall_left = 150;
            end
            if (stall_left > 0)
            begin
                char_out.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                char_out.ready <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else if ($urandom_range(0, 39) == 0)
                    burst_left = 40;
                else
                    stall_left = pick_idle();
            end
        end
    end

    // Compare each character transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && char_out.valid && char_out.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected character expected none got char_code %h last %b",
                         $time, char_out.char_code, char_out.last);
                fail_count++;
            end
            else
            begin
                oldest = expected_chars.pop_front();
                if (char_out.char_code !== oldest.ch)
                begin
                    $display("%0t: char_code expected %h got %h",
                             $time, oldest.ch, char_out.char_code);
                    fail_count++;
                end
                if (char_out.last !== oldest.last)
                begin
                    $display("%0t: last expected %b got %b",
                             $time, oldest.last, char_out.last);
                    fail_count++;
                end
            end
        end
    end

    // Run limit
    initial
        cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run limit reached", $time);
            $display("tb_morse_symbol_decoder NOT OK");
            $finish;
        end
    end

endmodule
